[design/fvm_pkg.sv]
// fvm_pkg: payload structs, codes and constants of the voltage modulator.
// Used by every module in design/; depends on nothing.
package fvm_pkg;

    typedef struct packed {
        logic [9:0]         encoder_position;
        logic signed [15:0] vd_command;
        logic signed [15:0] vq_command;
        logic [15:0]        bus_voltage;
    } fvm_in_t;

    typedef struct packed {
        logic [15:0] duty_a;
        logic [15:0] duty_b;
        logic [15:0] duty_c;
        logic        clipped;
    } fvm_out_t;

    // job handed from front to back: angle plus the voltage commands
    typedef struct packed {
        logic [31:0]        phase;
        logic signed [15:0] vd;
        logic signed [15:0] vq;
        logic [15:0]        bus;
    } fvm_job_t;

    localparam logic [1:0] MODE_ENCODER = 2'd0;
    localparam logic [1:0] MODE_RAMP    = 2'd1;
    localparam logic [1:0] MODE_FORCE   = 2'd2;
    localparam logic [1:0] MODE_HOLD    = 2'd3;

    localparam logic [0:0] REG_ANGLE_MODE = 1'd0;
    localparam logic [0:0] REG_RAMP_STEP  = 1'd1;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
    localparam logic signed [17:0] HALF_SQRT3_Q16 = 18'sd56756;

    function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
        logic signed [33:0] r;
        begin
            case (i)
                5'd0:  r = 34'sh020000000;
                5'd1:  r = 34'sh012E4051E;
                5'd2:  r = 34'sh009FB385B;
                5'd3:  r = 34'sh0051111D4;
                5'd4:  r = 34'sh0028B0D43;
                5'd5:  r = 34'sh00145D7E1;
                5'd6:  r = 34'sh000A2F61E;
                5'd7:  r = 34'sh000517C55;
                5'd8:  r = 34'sh00028BE53;
                5'd9:  r = 34'sh000145F2F;
                5'd10: r = 34'sh0000A2F98;
                5'd11: r = 34'sh0000517CC;
                5'd12: r = 34'sh000028BE6;
                5'd13: r = 34'sh0000145F3;
                5'd14: r = 34'sh00000A2FA;
                5'd15: r = 34'sh00000517D;
                5'd16: r = 34'sh0000028BE;
                5'd17: r = 34'sh00000145F;
                5'd18: r = 34'sh000000A30;
                5'd19: r = 34'sh000000518;
                5'd20: r = 34'sh00000028C;
                5'd21: r = 34'sh000000146;
                5'd22: r = 34'sh0000000A3;
                5'd23: r = 34'sh000000051;
                default: r = 34'sh0;
            endcase
            return r;
        end
    endfunction

endpackage

[design/fvm_front.sv]
// fvm_front: accepts ticks, applies the angle mode, keeps ramp/held state.
// Depends on fvm_pkg. Angles come from a reciprocal multiply: partial products, then their sum.
module fvm_front import fvm_pkg::*; #(
    parameter int ENCODER_COUNTS = 1024,
    parameter int RAMP_WRAP      = 100000
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  fvm_in_t     in_data,
    input  logic [1:0]  angle_mode,
    input  logic [16:0] ramp_step,
    output logic        job_valid,
    input  logic        job_full,
    output fvm_job_t    job_data
);
    localparam int CW = $clog2(RAMP_WRAP + 1);
    // ramp counter also holds a raw encoder count after encoder mode
    localparam int RW = (CW > 10) ? CW : 10;
    localparam int SW = (RW > 17) ? RW + 1 : 18;
    localparam int NW = $clog2(ENCODER_COUNTS + 1);
    // count * 2^32 / D == (count * M) >> S, M = ceil(2^(32+S) / D), exact while count * D < 2^S
    localparam int SH_ENC  = 10 + NW;
    localparam int SH_RAMP = 2 * CW;
    localparam logic [63:0] M_ENC = 64'(((128'd1 << (32 + SH_ENC)) + 128'(ENCODER_COUNTS)
                                         - 128'd1) / 128'(ENCODER_COUNTS));
    localparam logic [63:0] M_RAMP = 64'(((128'd1 << (32 + SH_RAMP)) + 128'(RAMP_WRAP)
                                          - 128'd1) / 128'(RAMP_WRAP));

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [RW-1:0]    ramp_reg;
    logic [31:0]      held_reg;
    logic [RW-1:0]    mul_a_reg;
    logic             mul_enc_reg;
    logic [RW+31:0]   plo_reg, phi_reg;
    fvm_in_t          hold_reg;

    logic [SW-1:0]    sum;
    logic [RW-1:0]    ramp_new;
    logic [31:0]      m_lo, m_hi;
    logic [RW+63:0]   prod;
    logic [31:0]      phase_new;

    assign in_stall = (state_reg != ST_IDLE);
    assign sum = SW'(ramp_reg) + SW'(ramp_step);
    assign ramp_new = (sum > SW'(RAMP_WRAP)) ? '0 : RW'(sum);
    assign m_lo = mul_enc_reg ? M_ENC[31:0] : M_RAMP[31:0];
    assign m_hi = mul_enc_reg ? M_ENC[63:32] : M_RAMP[63:32];
    assign prod = {phi_reg, 32'h0} + (RW+64)'(plo_reg);
    // truncation to 32 bits wraps a full turn to zero
    assign phase_new = mul_enc_reg ? 32'(prod >> SH_ENC) : 32'(prod >> SH_RAMP);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (angle_mode)
                        MODE_ENCODER, MODE_RAMP: state_next = ST_MUL;
                        MODE_HOLD:               state_next = ST_PUSH;
                        default: ;
                    endcase
                end
            end
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_PUSH;
            ST_PUSH: if (!job_full) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ramp_reg  <= '0;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && in_valid)
            begin
                case (angle_mode)
                    MODE_ENCODER: ramp_reg <= RW'(in_data.encoder_position);
                    MODE_RAMP:    ramp_reg <= ramp_new;
                    default: ;
                endcase
            end
            else if (state_reg == ST_ADD)
                held_reg <= phase_new;
        end
    end

    // operand capture, then two partial products of the reciprocal
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            hold_reg    <= in_data;
            mul_enc_reg <= (angle_mode == MODE_ENCODER);
            mul_a_reg   <= (angle_mode == MODE_ENCODER) ? RW'(in_data.encoder_position)
                                                        : ramp_new;
        end
        else if (state_reg == ST_MUL)
        begin
            plo_reg <= (RW+32)'(mul_a_reg) * (RW+32)'(m_lo);
            phi_reg <= (RW+32)'(mul_a_reg) * (RW+32)'(m_hi);
        end
    end

    assign job_valid = (state_reg == ST_PUSH);
    assign job_data.phase = held_reg;
    assign job_data.vd = hold_reg.vd_command;
    assign job_data.vq = hold_reg.vq_command;
    assign job_data.bus = hold_reg.bus_voltage;
endmodule

[design/fvm_queue.sv]
// fvm_queue: two-entry job queue between front and back.
// Depends on fvm_pkg.
module fvm_queue import fvm_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    output logic     full,
    input  fvm_job_t push_data,
    output logic     not_empty,
    input  logic     pop,
    output fvm_job_t pop_data
);
    fvm_job_t   mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full = (cnt_reg == 2'd2);
    assign not_empty = (cnt_reg != 2'd0);
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full) wp_reg <= ~wp_reg;
            if (pop && not_empty) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
        end
    end
endmodule

[design/fvm_back.sv]
// fvm_back: CORDIC, voltage normalizing divides, inverse Park/Clarke, duties.
// Depends on fvm_pkg. One shared CORDIC stage, one bit-serial divider.
module fvm_back import fvm_pkg::*; #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_pop,
    input  fvm_job_t job_data,
    output logic     out_valid,
    input  logic     out_stall,
    output fvm_out_t out_data
);
    localparam int NIT = (CORDIC_ITERATIONS < ATAN_ENTRIES) ? CORDIC_ITERATIONS : ATAN_ENTRIES;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CORD = 4'd1;
    localparam logic [3:0] ST_DIVD = 4'd2;
    localparam logic [3:0] ST_DIVQ = 4'd3;
    localparam logic [3:0] ST_ROT  = 4'd4;
    localparam logic [3:0] ST_SUM  = 4'd5;
    localparam logic [3:0] ST_CLK  = 4'd6;
    localparam logic [3:0] ST_CSUM = 4'd7;
    localparam logic [3:0] ST_DUTY = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    logic [3:0]         state_reg;
    logic [4:0]         it_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic               flip_reg;
    fvm_job_t           job_reg;
    logic               clip_reg;
    // divider: |v| << 16 by bus, 32 quotient bits
    logic [5:0]         dbit_reg;
    logic [31:0]        dnum_reg;
    logic [16:0]        drem_reg;
    logic signed [17:0] dn_reg, qn_reg, s_reg, c_reg;
    logic signed [35:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [18:0] alpha_reg, beta_reg, pb_reg;
    logic signed [36:0] ca_reg, cb_reg;
    fvm_out_t           out_reg;

    logic signed [33:0] dx, dy, x_f, y_f;
    logic [31:0]        p_fold;
    logic [17:0]        dtrial;
    logic [31:0]        qmag;
    logic signed [17:0] nsat;
    logic               nclip;
    logic signed [17:0] sx, sy;
    logic signed [19:0] pc;
    logic [16:0]        da, db, dc;
    logic               ka, kb, kc;

    function automatic logic [16:0] duty(input logic signed [19:0] v, output logic k);
        logic signed [20:0] d;
        begin
            d = (21'(v) + 21'sd65536) >>> 1;
            k = 1'b0;
            if (d < 0) begin k = 1'b1; d = '0; end
            else if (d > 21'sd65535) begin k = 1'b1; d = 21'sd65535; end
            return 17'(d);
        end
    endfunction

    assign dx = y_reg >>> it_reg;
    assign dy = x_reg >>> it_reg;
    assign p_fold = (job_data.phase + 32'h40000000) >= 32'h80000000 ?
                    job_data.phase - 32'h80000000 : job_data.phase;
    assign dtrial = {drem_reg, dnum_reg[31]};
    // sign from numerator; magnitude quotient then saturation to Q2.16
    assign qmag = {dnum_reg[30:0], (dtrial >= {2'b0, job_reg.bus})};
    always_comb
    begin
        logic neg;
        neg = (state_reg == ST_DIVD) ? job_reg.vd[15] : job_reg.vq[15];
        nclip = 1'b0;
        if (!neg && qmag > 32'd131071) begin nsat = 18'sd131071; nclip = 1'b1; end
        else if (neg && qmag > 32'd131072) begin nsat = -18'sd131072; nclip = 1'b1; end
        else nsat = neg ? -18'(qmag) : 18'(qmag);
    end
    assign x_f = (x_reg + 34'sd8192) >>> 14;
    assign y_f = (y_reg + 34'sd8192) >>> 14;
    assign sx = flip_reg ? -18'(x_f) : 18'(x_f);
    assign sy = flip_reg ? -18'(y_f) : 18'(y_f);
    assign pc = -20'(alpha_reg) - 20'(pb_reg);

    always_comb
    begin
        da = duty(20'(alpha_reg), ka);
        db = duty(20'(pb_reg), kb);
        dc = duty(pc, kc);
    end

    assign job_pop = (state_reg == ST_IDLE) && job_valid;
    assign out_valid = (state_reg == ST_OUT);
    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE: if (job_valid) state_reg <= (job_data.bus == '0) ? ST_OUT : ST_CORD;
                ST_CORD: if (it_reg == 5'(NIT - 1)) state_reg <= ST_DIVD;
                ST_DIVD: if (dbit_reg == 6'd31) state_reg <= ST_DIVQ;
                ST_DIVQ: if (dbit_reg == 6'd31) state_reg <= ST_ROT;
                ST_ROT:  state_reg <= ST_SUM;
                ST_SUM:  state_reg <= ST_CLK;
                ST_CLK:  state_reg <= ST_CSUM;
                ST_CSUM: state_reg <= ST_DUTY;
                ST_DUTY: state_reg <= ST_OUT;
                ST_OUT:  if (!out_stall) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                job_reg  <= job_data;
                flip_reg <= (job_data.phase + 32'h40000000) >= 32'h80000000;
                z_reg    <= 34'(signed'(p_fold));
                x_reg    <= CORDIC_GAIN;
                y_reg    <= '0;
                it_reg   <= '0;
                clip_reg <= 1'b0;
                dbit_reg <= '0;
                drem_reg <= '0;
                dnum_reg <= {job_data.vd[15] ? 16'(-job_data.vd) : 16'(job_data.vd), 16'h0};
                out_reg  <= '{duty_a: 16'd32768, duty_b: 16'd32768,
                              duty_c: 16'd32768, clipped: 1'b1};
            end
            ST_CORD:
            begin
                it_reg <= it_reg + 5'd1;
                if (!z_reg[33])
                begin
                    x_reg <= x_reg - dx; y_reg <= y_reg + dy; z_reg <= z_reg - atan_turn(it_reg);
                end
                else
                begin
                    x_reg <= x_reg + dx; y_reg <= y_reg - dy; z_reg <= z_reg + atan_turn(it_reg);
                end
            end
            ST_DIVD, ST_DIVQ:
            begin
                if (dbit_reg == 6'd31)
                begin
                    // last quotient bit: store, then restart for the next divide
                    dbit_reg <= '0;
                    drem_reg <= '0;
                    clip_reg <= clip_reg | nclip;
                    if (state_reg == ST_DIVD)
                    begin
                        dn_reg <= nsat;
                        dnum_reg <= {job_reg.vq[15] ? 16'(-job_reg.vq) : 16'(job_reg.vq),
                                     16'h0};
                    end
                    else
                    begin
                        qn_reg <= nsat;
                        dnum_reg <= qmag;
                    end
                    s_reg <= sy;
                    c_reg <= sx;
                end
                else
                begin
                    dbit_reg <= dbit_reg + 6'd1;
                    if (dtrial >= {2'b0, job_reg.bus})
                        drem_reg <= 17'(dtrial - {2'b0, job_reg.bus});
                    else
                        drem_reg <= 17'(dtrial);
                    dnum_reg <= qmag;
                end
            end
            ST_ROT:
            begin
                p0_reg <= dn_reg * c_reg;
                p1_reg <= qn_reg * s_reg;
                p2_reg <= dn_reg * s_reg;
                p3_reg <= qn_reg * c_reg;
            end
            ST_SUM:
            begin
                alpha_reg <= 19'((37'(p0_reg) - 37'(p1_reg) + 37'sd32768) >>> 16);
                beta_reg  <= 19'((37'(p2_reg) + 37'(p3_reg) + 37'sd32768) >>> 16);
            end
            ST_CLK:
            begin
                ca_reg <= -37'(alpha_reg) * 37'sd32768;
                cb_reg <= 37'(beta_reg) * 37'(HALF_SQRT3_Q16);
            end
            ST_CSUM: pb_reg <= 19'((ca_reg + cb_reg + 37'sd32768) >>> 16);
            ST_DUTY:
            begin
                out_reg.duty_a  <= da[15:0];
                out_reg.duty_b  <= db[15:0];
                out_reg.duty_c  <= dc[15:0];
                out_reg.clipped <= clip_reg | ka | kb | kc;
            end
            default: ;
        endcase
    end
endmodule

[design/foc_voltage_modulator.sv]
// foc_voltage_modulator: top level, config registers, front/queue/back.
// Depends on fvm_pkg, fvm_front, fvm_queue, fvm_back.
//
// Each accepted tick beat yields one result beat (duties a/b/c in Q0.16 and
// a clipped flag), except in force-PWM mode (angle_mode 2), which takes the
// beat and returns nothing. The front resolves the angle: hold mode goes from
// accept straight to hand off, encoder and ramp modes accept, run the
// reciprocal multiply (partial products, then their sum) and hand off. The
// back takes the job, runs CORDIC_ITERATIONS sine/cosine iterations (at most
// 24), the two normalizing divides by bus voltage, then rotation, Clarke and
// duty, and presents the result (a zero bus voltage goes straight from
// taking the job to presenting the result). The back sets the rate.
// A two-beat queue lets the front take the next tick while the back works.
// Write config only when idle.
module foc_voltage_modulator import fvm_pkg::*; #(
    parameter int ENCODER_COUNTS    = 1024,
    parameter int RAMP_WRAP         = 100000,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  fvm_in_t     in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output fvm_out_t    out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    logic [1:0]  angle_mode_reg;
    logic [16:0] ramp_step_reg;
    logic        job_valid, job_full, q_nempty, q_pop;
    fvm_job_t    job_data, q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_mode_reg <= MODE_ENCODER;
            ramp_step_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ANGLE_MODE: angle_mode_reg <= cfg_data[1:0];
                REG_RAMP_STEP:  ramp_step_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    fvm_front #(.ENCODER_COUNTS(ENCODER_COUNTS), .RAMP_WRAP(RAMP_WRAP)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .angle_mode(angle_mode_reg), .ramp_step(ramp_step_reg),
        .job_valid(job_valid), .job_full(job_full), .job_data(job_data)
    );

    fvm_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(job_valid), .full(job_full), .push_data(job_data),
        .not_empty(q_nempty), .pop(q_pop), .pop_data(q_data)
    );

    fvm_back #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(q_nempty), .job_pop(q_pop), .job_data(q_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );
endmodule

[tb/tb_top.sv]
// tb_top: self-checking bench for foc_voltage_modulator.
// Depends on fvm_pkg and design/foc_voltage_modulator.sv.
module tb_top;
    import fvm_pkg::*;

    localparam int ENC_COUNTS = 1024;
    localparam int RAMP_LIMIT = 100000;
    localparam int CORDIC_ITERS = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM = 1550;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    fvm_in_t     in_data;
    logic        out_valid;
    logic        out_stall;
    fvm_out_t    out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [16:0] cfg_data;

    foc_voltage_modulator #(
        .ENCODER_COUNTS(ENC_COUNTS),
        .RAMP_WRAP(RAMP_LIMIT),
        .CORDIC_ITERATIONS(CORDIC_ITERS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state: registers and the block's own state
    logic [1:0]  mode_q;
    logic [16:0] step_q;
    logic [16:0] ramp_q;
    logic [31:0] phase_q;

    fvm_in_t  tick_queue[$];
    fvm_out_t duty_queue[$];
    int       mismatches;
    int       idle_cycles;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // floor shift of a signed value
    function automatic longint fshift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic void sin_cos(input logic [31:0] ph, output longint s_o,
                                    output longint c_o);
        logic [31:0] p;
        bit     flip;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        flip = ((ph + 32'h4000_0000) & 32'h8000_0000) != 0;
        p = flip ? ph - 32'h8000_0000 : ph;
        z = longint'($signed(p));
        x = longint'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < CORDIC_ITERS && i < ATAN_ENTRIES; i++)
        begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= longint'(atan_turn(i[4:0]));
            end
            else
            begin
                x += dx; y -= dy; z += longint'(atan_turn(i[4:0]));
            end
        end
        x = fshift(x + 8192, 14);
        y = fshift(y + 8192, 14);
        c_o = flip ? -x : x;
        s_o = flip ? -y : y;
    endfunction

    function automatic longint scale_to_bus(input longint v, input longint bus,
                                            inout bit clip);
        longint n;
        n = (v * 65536) / bus;
        if (n > 131071) begin clip = 1; return 131071; end
        if (n < -131072) begin clip = 1; return -131072; end
        return n;
    endfunction

    function automatic logic [15:0] duty_of(input longint v, inout bit clip);
        longint d;
        d = fshift(v + 65536, 1);
        if (d < 0) begin clip = 1; return 16'd0; end
        if (d > 65535) begin clip = 1; return 16'hFFFF; end
        return d[15:0];
    endfunction

    // updates angle state and pushes the expected duties, if any
    task automatic predict_duties(input fvm_in_t t);
        longint s, c, dn, qn, alpha, beta, pb, pc;
        logic [17:0] sum;
        bit clip;
        fvm_out_t r;
        clip = 0;
        if (mode_q == MODE_FORCE)
            return;
        if (mode_q == MODE_ENCODER)
        begin
            ramp_q = {7'd0, t.encoder_position};
            phase_q = 32'((64'(t.encoder_position) << 32) / ENC_COUNTS);
        end
        else if (mode_q == MODE_RAMP)
        begin
            sum = 18'(ramp_q) + 18'(step_q);
            ramp_q = (sum > RAMP_LIMIT) ? 17'd0 : sum[16:0];
            phase_q = 32'((64'(ramp_q) << 32) / RAMP_LIMIT);
        end
        if (t.bus_voltage == 0)
        begin
            r = '{16'd32768, 16'd32768, 16'd32768, 1'b1};
            duty_queue.push_back(r);
            return;
        end
        sin_cos(phase_q, s, c);
        dn = scale_to_bus(longint'(t.vd_command), longint'(t.bus_voltage), clip);
        qn = scale_to_bus(longint'(t.vq_command), longint'(t.bus_voltage), clip);
        alpha = fshift(dn * c - qn * s + 32768, 16);
        beta = fshift(dn * s + qn * c + 32768, 16);
        pb = fshift(-alpha * 32768 + beta * 56756 + 32768, 16);
        pc = -alpha - pb;
        r.duty_a = duty_of(alpha, clip);
        r.duty_b = duty_of(pb, clip);
        r.duty_c = duty_of(pc, clip);
        r.clipped = clip;
        duty_queue.push_back(r);
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        mismatches++;
        $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    // driver: inputs move on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!(in_valid && in_stall))
            begin
                if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= tick_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor: accepted beats at the rising edge
    always @(posedge clk)
    begin
        fvm_out_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_duties(in_data);
            if (out_valid && !out_stall)
            begin
                if (duty_queue.size() == 0)
                    report("unexpected result beat, duty_a", 32'(out_data.duty_a), 32'd0);
                else
                begin
                    want = duty_queue.pop_front();
                    if (out_data.duty_a !== want.duty_a)
                        report("duty_a", 32'(out_data.duty_a), 32'(want.duty_a));
                    if (out_data.duty_b !== want.duty_b)
                        report("duty_b", 32'(out_data.duty_b), 32'(want.duty_b));
                    if (out_data.duty_c !== want.duty_c)
                        report("duty_c", 32'(out_data.duty_c), 32'(want.duty_c));
                    if (out_data.clipped !== want.clipped)
                        report("clipped", 32'(out_data.clipped), 32'(want.clipped));
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // register write, only while the block is idle; predictor updates in step
    task automatic write_reg(input logic [0:0] idx, input logic [16:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_ANGLE_MODE)
            mode_q = val[1:0];
        else
            step_q = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait for the queue to drain, plus slack for a no-result tick in flight
    task automatic drain();
        while (tick_queue.size() > 0 || in_valid || duty_queue.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic fvm_in_t rand_tick();
        fvm_in_t t;
        t.encoder_position = 10'($urandom_range(1023));
        case ($urandom_range(9))
            0: t.bus_voltage = 16'd0;
            1: t.bus_voltage = 16'($urandom_range(16));
            2, 3: t.bus_voltage = 16'($urandom);
            default: t.bus_voltage = 16'($urandom_range(40000, 20000));
        endcase
        if ($urandom_range(3) == 0)
        begin
            t.vd_command = 16'($urandom);
            t.vq_command = 16'($urandom);
        end
        else
        begin
            // mostly in-range commands relative to the bus
            t.vd_command = 16'($signed($urandom_range(2 * t.bus_voltage / 3 + 1)) -
                                $signed(32'(t.bus_voltage / 3)));
            t.vq_command = 16'($signed($urandom_range(2 * t.bus_voltage / 3 + 1)) -
                                $signed(32'(t.bus_voltage / 3)));
        end
        return t;
    endfunction

    task automatic push_tick(input logic [9:0] p, input logic [15:0] d,
                             input logic [15:0] q, input logic [15:0] b);
        fvm_in_t t;
        t.encoder_position = p; t.vd_command = d;
        t.vq_command = q; t.bus_voltage = b;
        tick_queue.push_back(t);
    endtask

    initial
    begin
        logic [1:0] mode_seq[6];
        logic [16:0] step_seq[6];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ANGLE_MODE;
        cfg_data = '0;
        mode_q = MODE_ENCODER; step_q = '0; ramp_q = '0; phase_q = '0;
        mismatches = 0; idle_cycles = 0; hold_cycles = 0;
        send_idle_pct = 23; recv_idle_pct = 76;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes in encoder mode
        push_tick(10'd0, 16'h7FFF, 16'h8000, 16'hFFFF);
        push_tick(10'd1023, 16'h8000, 16'h7FFF, 16'd1);
        push_tick(10'd256, 16'd0, 16'd0, 16'd0);
        push_tick(10'd512, 16'd100, 16'd0, 16'd100);   // half-turn phase
        push_tick(10'd768, 16'd0, 16'd50, 16'd100);
        push_tick(10'd128, 16'h8000, 16'h8000, 16'd1);
        drain();
        // hold mode reuses the last angle
        write_reg(REG_ANGLE_MODE, 17'(MODE_HOLD));
        push_tick(10'd5, 16'd300, 16'd200, 16'd1000);
        push_tick(10'd900, 16'h8000, 16'd7, 16'd0);
        drain();
        // ramp: a step past the limit wraps, one reaches it exactly, and a zero step
        write_reg(REG_RAMP_STEP, 17'd99999);
        write_reg(REG_ANGLE_MODE, 17'(MODE_RAMP));
        push_tick(10'd0, 16'd10, 16'd20, 16'd100);
        push_tick(10'd0, 16'd10, 16'd20, 16'd100);
        drain();
        write_reg(REG_RAMP_STEP, 17'd100000);
        push_tick(10'd0, 16'd1, 16'd2, 16'd3);
        push_tick(10'd0, 16'd1, 16'd2, 16'd3);
        drain();
        write_reg(REG_RAMP_STEP, 17'd0);
        push_tick(10'd0, 16'd1, 16'd2, 16'd3);
        drain();
        // force PWM produces nothing
        write_reg(REG_ANGLE_MODE, 17'(MODE_FORCE));
        push_tick(10'd3, 16'd1, 16'd1, 16'd1);
        push_tick(10'd4, 16'd1, 16'd1, 16'd0);
        drain();

        mode_seq = '{MODE_ENCODER, MODE_RAMP, MODE_HOLD, MODE_RAMP, MODE_FORCE,
                     MODE_ENCODER};
        step_seq = '{17'd1, 17'd100000, 17'd777, 17'd3, 17'd65536, 17'd1};
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2) begin send_idle_pct = 76; recv_idle_pct = 23; end
            if (ph == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
            write_reg(REG_ANGLE_MODE, 17'(mode_seq[ph]));
            write_reg(REG_RAMP_STEP, step_seq[ph] ^ 17'($urandom_range(1)));
            if (ph == 5)
                hold_cycles = 3000;   // long receiver hold-off, input backs up
            for (int k = 0; k < N_RANDOM / 6; k++)
                tick_queue.push_back(rand_tick());
            drain();
        end
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

[files.f]
design/fvm_pkg.sv
design/fvm_front.sv
design/fvm_queue.sv
design/fvm_back.sv
design/foc_voltage_modulator.sv
tb/tb_top.sv
